FILE: sv/qu_pkg.sv
// Shared types and constants of the quaternion unit.
package qu_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam int NUM_RES  = 9;
  localparam int MAT_ROWS = 3;

  localparam int SQRT_ITERS = 17;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_FRAC  = 30;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam int QUARTER_TURN_HALF = 11520;
  localparam int HALF_TURN_HALF    = 23040;

  localparam logic signed [24:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
    25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
    25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
    25'sd458,     25'sd229,    25'sd115,    25'sd57
  };

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_NORM = 2'd1,
    MODE_MAT  = 2'd2,
    MODE_AXIS = 2'd3
  } qu_mode_e;

  typedef struct packed {
    qu_mode_e           mode;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] angle;
  } qu_in_t;

  typedef struct packed {
    logic signed [15:0] out_0;
    logic signed [15:0] out_1;
    logic signed [15:0] out_2;
    logic signed [15:0] out_3;
    logic               last;
    logic               zero_norm;
  } qu_out_t;

  // Finished item as it leaves the arithmetic pipeline
  typedef struct packed {
    qu_mode_e                  mode;
    logic                      zn;
    logic [NUM_RES-1:0][15:0]  res;
  } qu_res_t;

endpackage

FILE: sv/qu_pipe.sv
// Arithmetic pipeline of the quaternion unit: product, normalise, matrix, axis-angle.
module qu_pipe import qu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  qu_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    pop_i,
  output qu_res_t out_res_o
);

  localparam int F   = FRAC_BITS;
  localparam int SW  = ((2 * F > 34) ? 2 * F : 34) + 3;
  localparam int NW  = F + 18;
  localparam int QW  = F + 1;
  localparam int CS  = CORDIC_FRAC - F;

  localparam int ST_MUL     = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_CRD     = 2;
  localparam int ST_CMUL    = ST_CRD + CORDIC_STEPS / 2;
  localparam int ST_CRND    = ST_CMUL + 1;
  localparam int ST_SQ      = 3;
  localparam int ST_DPRE    = ST_SQ + (SQRT_ITERS + 1) / 2;
  localparam int ST_DIV     = ST_DPRE + 1;
  localparam int DIV_STAGES = (F + 2) / 2;
  localparam int ST_FIN     = ST_DIV + DIV_STAGES;
  localparam int NS         = ST_FIN + 1;

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] HALF_F = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [SW-1:0] ONE_2F = SW'(64'sd1 <<< (2 * F));
  localparam logic signed [SW-1:0] CRND   = SW'((64'sd1 <<< CS) >>> 1);

  typedef struct packed {
    qu_mode_e               mode;
    logic [3:0][15:0]       a;
    logic [3:0][15:0]       b;
    logic [15:0]            ang;
    logic [15:0][31:0]      p;
    logic [NUM_RES-1:0][15:0] res;
    logic                   zn;
    logic [33:0]            n;
    logic [33:0]            r;
    logic [32:0]            cx;
    logic [32:0]            cy;
    logic [24:0]            cz;
    logic                   neg;
    logic [2:0][48:0]       cp;
    logic [16:0]            m;
    logic [3:0][NW-1:0]     rem;
    logic [3:0][QW-1:0]     q;
    logic [3:0]             sgn;
  } stg_t;

  stg_t          st_q [NS];
  stg_t          st_d [NS];
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  function automatic logic [15:0] sat16(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    if (v > SAT_HI) begin
      t = SAT_HI;
    end else if (v < SAT_LO) begin
      t = SAT_LO;
    end else begin
      t = v;
    end
    return t[15:0];
  endfunction

  function automatic logic [15:0] rnd_f(input logic signed [SW-1:0] v);
    return sat16((v + HALF_F) >>> F);
  endfunction

  function automatic stg_t do_mul(input stg_t s);
    stg_t r;
    logic signed [15:0] w, x, y, z, bw, bx, by, bz;
    logic signed [15:0] oa [16];
    logic signed [15:0] ob [16];
    logic signed [16:0] h;
    r  = s;
    w  = $signed(s.a[0]);
    x  = $signed(s.a[1]);
    y  = $signed(s.a[2]);
    z  = $signed(s.a[3]);
    bw = $signed(s.b[0]);
    bx = $signed(s.b[1]);
    by = $signed(s.b[2]);
    bz = $signed(s.b[3]);
    oa = '{w, x, y, z, w, x, y, z, w, x, y, z, w, x, y, z};
    ob = '{bw, bx, by, bz, bx, bw, bz, by, by, bz, bw, bx, bz, by, bx, bw};
    case (s.mode)
      MODE_NORM: begin
        for (int i = 0; i < 4; i++) begin
          oa[i] = $signed(s.a[i]);
          ob[i] = $signed(s.a[i]);
        end
      end
      MODE_MAT: begin
        oa[0] = x; ob[0] = x;
        oa[1] = y; ob[1] = y;
        oa[2] = z; ob[2] = z;
        oa[3] = x; ob[3] = y;
        oa[4] = x; ob[4] = z;
        oa[5] = y; ob[5] = z;
        oa[6] = w; ob[6] = x;
        oa[7] = w; ob[7] = y;
        oa[8] = w; ob[8] = z;
      end
      default: ;
    endcase
    for (int i = 0; i < 16; i++) begin
      r.p[i] = oa[i] * ob[i];
    end
    // fold the half angle into +-90 degrees; sine and cosine flip sign
    h     = 17'($signed(s.ang));
    r.neg = 1'b0;
    if (h > QUARTER_TURN_HALF) begin
      h     = h - 17'(HALF_TURN_HALF);
      r.neg = 1'b1;
    end else if (h < -QUARTER_TURN_HALF) begin
      h     = h + 17'(HALF_TURN_HALF);
      r.neg = 1'b1;
    end
    r.cz = {h, 8'b0};
    r.cx = CORDIC_GAIN;
    r.cy = '0;
    return r;
  endfunction

  function automatic stg_t do_sum(input stg_t s);
    stg_t r;
    logic signed [SW-1:0] pv [16];
    r = s;
    for (int i = 0; i < 16; i++) begin
      pv[i] = SW'($signed(s.p[i]));
    end
    if (s.mode == MODE_MUL) begin
      r.res[0] = rnd_f(pv[0] - pv[1] - pv[2] - pv[3]);
      r.res[1] = rnd_f(pv[4] + pv[5] + pv[6] - pv[7]);
      r.res[2] = rnd_f(pv[8] - pv[9] + pv[10] + pv[11]);
      r.res[3] = rnd_f(pv[12] + pv[13] - pv[14] + pv[15]);
    end
    if (s.mode == MODE_MAT) begin
      r.res[0] = rnd_f(ONE_2F - ((pv[1] + pv[2]) <<< 1));
      r.res[1] = rnd_f((pv[3] - pv[8]) <<< 1);
      r.res[2] = rnd_f((pv[4] + pv[7]) <<< 1);
      r.res[3] = rnd_f((pv[3] + pv[8]) <<< 1);
      r.res[4] = rnd_f(ONE_2F - ((pv[0] + pv[2]) <<< 1));
      r.res[5] = rnd_f((pv[5] - pv[6]) <<< 1);
      r.res[6] = rnd_f((pv[4] - pv[7]) <<< 1);
      r.res[7] = rnd_f((pv[5] + pv[6]) <<< 1);
      r.res[8] = rnd_f(ONE_2F - ((pv[0] + pv[1]) <<< 1));
    end
    r.n = 34'(s.p[0]) + 34'(s.p[1]) + 34'(s.p[2]) + 34'(s.p[3]);
    r.r = '0;
    return r;
  endfunction

  function automatic stg_t do_crd(input stg_t s, input int i0);
    stg_t r;
    logic signed [32:0] cx, cy, dx, dy;
    logic signed [24:0] cz;
    r  = s;
    cx = $signed(s.cx);
    cy = $signed(s.cy);
    cz = $signed(s.cz);
    for (int t = 0; t < 2; t++) begin
      if (i0 + t < CORDIC_STEPS) begin
        dx = cy >>> (i0 + t);
        dy = cx >>> (i0 + t);
        if (cz >= 0) begin
          cx = cx - dx;
          cy = cy + dy;
          cz = cz - ATAN_TAB[i0 + t];
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          cz = cz + ATAN_TAB[i0 + t];
        end
      end
    end
    r.cx = cx;
    r.cy = cy;
    r.cz = cz;
    return r;
  endfunction

  function automatic stg_t do_cmul(input stg_t s);
    stg_t r;
    logic signed [32:0]   cxn, cyn;
    logic signed [SW-1:0] t;
    r   = s;
    cxn = s.neg ? -$signed(s.cx) : $signed(s.cx);
    cyn = s.neg ? -$signed(s.cy) : $signed(s.cy);
    t   = SW'(cxn);
    if (s.mode == MODE_AXIS) begin
      r.res[0] = sat16((t + CRND) >>> CS);
    end
    for (int i = 0; i < 3; i++) begin
      r.cp[i] = cyn * $signed(s.a[i + 1]);
    end
    return r;
  endfunction

  function automatic stg_t do_crnd(input stg_t s);
    stg_t r;
    logic signed [49:0]   v;
    logic signed [SW-1:0] u;
    r = s;
    for (int i = 0; i < 3; i++) begin
      v = 50'($signed(s.cp[i]));
      v = (v + (50'sd1 <<< (CORDIC_FRAC - 1))) >>> CORDIC_FRAC;
      u = SW'(v);
      if (s.mode == MODE_AXIS) begin
        r.res[i + 1] = sat16(u);
      end
    end
    return r;
  endfunction

  function automatic stg_t do_sqrt(input stg_t s, input int j0);
    stg_t r;
    logic [33:0] bitv;
    r = s;
    for (int t = 0; t < 2; t++) begin
      if (j0 + t < SQRT_ITERS) begin
        bitv = 34'd1 << (2 * (SQRT_ITERS - 1 - j0 - t));
        if (r.n >= r.r + bitv) begin
          r.n = r.n - (r.r + bitv);
          r.r = (r.r >> 1) + bitv;
        end else begin
          r.r = r.r >> 1;
        end
      end
    end
    return r;
  endfunction

  function automatic stg_t do_dpre(input stg_t s);
    stg_t r;
    logic signed [16:0] av;
    logic [16:0]        mag;
    r    = s;
    r.m  = s.r[16:0];
    r.zn = (s.mode == MODE_NORM) && (s.r[16:0] == '0);
    for (int i = 0; i < 4; i++) begin
      av       = 17'($signed(s.a[i]));
      mag      = (av < 0) ? 17'(-av) : 17'(av);
      r.sgn[i] = av < 0;
      r.rem[i] = (NW'(mag) << F) + NW'(s.r[16:1]);
      r.q[i]   = '0;
    end
    return r;
  endfunction

  function automatic stg_t do_div(input stg_t s, input int b0);
    stg_t r;
    logic [NW-1:0] dv;
    r = s;
    for (int t = 0; t < 2; t++) begin
      if (b0 - t >= 0) begin
        dv = NW'(s.m) << (b0 - t);
        for (int i = 0; i < 4; i++) begin
          if (r.rem[i] >= dv) begin
            r.rem[i]        = r.rem[i] - dv;
            r.q[i][b0 - t]  = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic stg_t do_fin(input stg_t s);
    stg_t r;
    logic signed [SW-1:0] qv;
    r = s;
    if (s.mode == MODE_NORM) begin
      for (int i = 0; i < 4; i++) begin
        qv = SW'(s.q[i]);
        if (s.sgn[i]) begin
          qv = -qv;
        end
        r.res[i] = s.zn ? 16'd0 : sat16(qv);
      end
    end
    return r;
  endfunction

  always_comb begin
    st_d[0]      = '0;
    st_d[0].mode = in_data_i.mode;
    st_d[0].a    = {in_data_i.a_z, in_data_i.a_y, in_data_i.a_x, in_data_i.a_w};
    st_d[0].b    = {in_data_i.b_z, in_data_i.b_y, in_data_i.b_x, in_data_i.b_w};
    st_d[0].ang  = in_data_i.angle;
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    always_comb begin
      stg_t nx;
      nx = st_q[k-1];
      if (k == ST_MUL) nx = do_mul(nx);
      if (k == ST_SUM) nx = do_sum(nx);
      if (k >= ST_CRD && k < ST_CMUL) nx = do_crd(nx, 2 * (k - ST_CRD));
      if (k == ST_CMUL) nx = do_cmul(nx);
      if (k == ST_CRND) nx = do_crnd(nx);
      if (k >= ST_SQ && k < ST_DPRE) nx = do_sqrt(nx, 2 * (k - ST_SQ));
      if (k == ST_DPRE) nx = do_dpre(nx);
      if (k >= ST_DIV && k < ST_FIN) nx = do_div(nx, F - 2 * (k - ST_DIV));
      if (k == ST_FIN) nx = do_fin(nx);
      st_d[k] = nx;
    end
  end

  // a stage takes new data when it is empty or its own contents move on
  assign en[NS-1] = !v_q[NS-1] || pop_i;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign in_ready_o      = en[0];
  assign out_valid_o     = v_q[NS-1];
  assign out_res_o.mode  = st_q[NS-1].mode;
  assign out_res_o.zn    = st_q[NS-1].zn;
  assign out_res_o.res   = st_q[NS-1].res;

endmodule

FILE: sv/quaternion_unit.sv
// Quaternion unit top level: arithmetic pipeline and result row sequencing.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (qu_in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (qu_out_t)
//
// One transaction enters per cycle while in_ready_o is high; the pipeline is 14 +
// (FRAC_BITS+2)/2 stages deep (22 at 14 fraction bits). Matrix mode holds the
// last stage for its three rows, one per handshake; the other modes give one
// result per cycle while out_ready_i is high. The square root and the divider
// stages set the depth. Reset clears the stage valid bits and the row count
// only. A stall at the output fills bubbles stage by stage before in_ready_o drops.
module quaternion_unit import qu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  qu_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output qu_out_t out_data_o
);

  qu_res_t    res;
  logic       pop;
  logic       last;
  logic [1:0] row_q, row_d;

  qu_pipe #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .pop_i       (pop),
    .out_res_o   (res)
  );

  assign last = (res.mode != MODE_MAT) || (row_q == 2'(MAT_ROWS - 1));
  assign pop  = out_valid_o && out_ready_i && last;

  always_comb begin
    row_d = row_q;
    if (out_valid_o && out_ready_i) begin
      row_d = last ? 2'd0 : row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  always_comb begin
    out_data_o.last      = last;
    out_data_o.zero_norm = res.zn;
    out_data_o.out_0     = $signed(res.res[0]);
    out_data_o.out_1     = $signed(res.res[1]);
    out_data_o.out_2     = $signed(res.res[2]);
    out_data_o.out_3     = $signed(res.res[3]);
    if (res.mode == MODE_MAT) begin
      out_data_o.out_3 = '0;
      case (row_q)
        2'd0: begin
          out_data_o.out_0 = $signed(res.res[0]);
          out_data_o.out_1 = $signed(res.res[1]);
          out_data_o.out_2 = $signed(res.res[2]);
        end
        2'd1: begin
          out_data_o.out_0 = $signed(res.res[3]);
          out_data_o.out_1 = $signed(res.res[4]);
          out_data_o.out_2 = $signed(res.res[5]);
        end
        default: begin
          out_data_o.out_0 = $signed(res.res[6]);
          out_data_o.out_1 = $signed(res.res[7]);
          out_data_o.out_2 = $signed(res.res[8]);
        end
      endcase
    end
  end

endmodule

FILE: sv/qu_checker.sv
// Port-level checks for the quaternion unit, bound to the top level.
module qu_checker import qu_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input qu_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // matrix rows follow each other without a gap
  a_rows_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap between matrix rows");

  a_row_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.out_3 == 16'sd0 && !out_data_o.zero_norm)
    else $error("bad matrix row");

  a_zero_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_norm |-> out_data_o.last &&
      out_data_o.out_0 == 16'sd0 && out_data_o.out_1 == 16'sd0 &&
      out_data_o.out_2 == 16'sd0 && out_data_o.out_3 == 16'sd0)
    else $error("zero magnitude result not cleared");

endmodule

bind quaternion_unit qu_checker u_qu_checker (.*);

FILE: sim/quaternion_unit_tb.sv
// Self-checking testbench of the quaternion unit: known results and a directed table, then random items.
module quaternion_unit_tb;
  import qu_pkg::*;

  localparam int ATAN_Q [16] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57
  };
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 390;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  qu_in_t  in_data = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  qu_out_t out_data;

  qu_out_t expected_q[$];
  int      err_count = 0;
  int      idle_cycles = 0;
  bit      busy_idle = 1'b1;
  bit      stall_free = 1'b0;

  quaternion_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  always #10 clk = ~clk;

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint div_half_away(longint n, longint m);
    longint an, q;
    an = (n < 0) ? -n : n;
    q = (an + m / 2) / m;
    return (n < 0) ? -q : q;
  endfunction

  function automatic qu_out_t pack_res(longint v0, longint v1, longint v2, longint v3,
                                       logic lst, logic zn);
    qu_out_t r;
    r.out_0 = clip16(v0);
    r.out_1 = clip16(v1);
    r.out_2 = clip16(v2);
    r.out_3 = clip16(v3);
    r.last = lst;
    r.zero_norm = zn;
    return r;
  endfunction

  // Work out the results of one item and queue them
  task automatic predict_quaternion(qu_in_t it);
    longint w, x, y, z, bw, bx, by, bz, m, one, h, cx, cy, cz, dx, dy;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    bit flip;
    w = it.a_w; x = it.a_x; y = it.a_y; z = it.a_z;
    bw = it.b_w; bx = it.b_x; by = it.b_y; bz = it.b_z;
    case (it.mode)
      MODE_MUL: begin
        expected_q.push_back(pack_res(
          rnd_shift(w*bw - x*bx - y*by - z*bz, 14),
          rnd_shift(w*bx + x*bw + y*bz - z*by, 14),
          rnd_shift(w*by - x*bz + y*bw + z*bx, 14),
          rnd_shift(w*bz + x*by - y*bx + z*bw, 14), 1'b1, 1'b0));
      end
      MODE_NORM: begin
        m = root_floor(w*w + x*x + y*y + z*z);
        one = longint'(1) <<< 14;
        if (m == 0) expected_q.push_back(pack_res(0, 0, 0, 0, 1'b1, 1'b1));
        else expected_q.push_back(pack_res(div_half_away(w*one, m),
          div_half_away(x*one, m), div_half_away(y*one, m),
          div_half_away(z*one, m), 1'b1, 1'b0));
      end
      MODE_MAT: begin
        one = longint'(1) <<< 28;
        xx = x*x; yy = y*y; zz = z*z; xy = x*y; xz = x*z; yz = y*z;
        wx = w*x; wy = w*y; wz = w*z;
        expected_q.push_back(pack_res(rnd_shift(one - 2*(yy+zz), 14),
          rnd_shift(2*(xy-wz), 14), rnd_shift(2*(xz+wy), 14), 0, 1'b0, 1'b0));
        expected_q.push_back(pack_res(rnd_shift(2*(xy+wz), 14),
          rnd_shift(one - 2*(xx+zz), 14), rnd_shift(2*(yz-wx), 14), 0, 1'b0, 1'b0));
        expected_q.push_back(pack_res(rnd_shift(2*(xz-wy), 14),
          rnd_shift(2*(yz+wx), 14), rnd_shift(one - 2*(xx+yy), 14), 0, 1'b1, 1'b0));
      end
      default: begin
        h = it.angle;
        flip = 1'b0;
        if (h > QUARTER_TURN_HALF) begin
          h = h - HALF_TURN_HALF;
          flip = 1'b1;
        end else if (h < -QUARTER_TURN_HALF) begin
          h = h + HALF_TURN_HALF;
          flip = 1'b1;
        end
        cx = 652032874; cy = 0; cz = h * 256;
        for (int i = 0; i < 16; i++) begin
          dx = fl_shift(cy, i);
          dy = fl_shift(cx, i);
          if (cz >= 0) begin
            cx = cx - dx; cy = cy + dy; cz = cz - ATAN_Q[i];
          end else begin
            cx = cx + dx; cy = cy - dy; cz = cz + ATAN_Q[i];
          end
        end
        if (flip) begin
          cx = -cx; cy = -cy;
        end
        expected_q.push_back(pack_res(rnd_shift(cx, 16), rnd_shift(cy*x, 30),
          rnd_shift(cy*y, 30), rnd_shift(cy*z, 30), 1'b1, 1'b0));
      end
    endcase
  endtask

  function automatic qu_in_t make_item(qu_mode_e md, int aw, int ax, int ay, int az,
                                       int bw, int bx, int by, int bz, int ang);
    qu_in_t it;
    it.mode = md;
    it.a_w = aw[15:0]; it.a_x = ax[15:0]; it.a_y = ay[15:0]; it.a_z = az[15:0];
    it.b_w = bw[15:0]; it.b_x = bx[15:0]; it.b_y = by[15:0]; it.b_z = bz[15:0];
    it.angle = ang[15:0];
    return it;
  endfunction

  function automatic qu_in_t random_item();
    qu_in_t it;
    int sel;
    it = qu_in_t'($bits(qu_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    it.mode = qu_mode_e'($urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    // mostly components between -1.0 and just under 1.0, sometimes tiny values, else raw full-range values
    if (sel < 6) begin
      it.a_w = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
      it.a_x = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
      it.a_y = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
      it.a_z = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
    end else if (sel == 6) begin
      it.a_w = 16'($signed(16'($urandom_range(0, 6))) - 3);
      it.a_x = 16'($signed(16'($urandom_range(0, 2))) - 1);
      it.a_y = '0;
      it.a_z = 16'($signed(16'($urandom_range(0, 2))) - 1);
    end
    return it;
  endfunction

  // Offer one item, holding valid until accepted; leave valid high for the next one
  task automatic send_item(qu_in_t it);
    while (busy_idle && ($urandom_range(0, 99) < 34)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_quaternion(it);
    @(negedge clk);
  endtask

  // Directed item whose result is typed in
  task automatic send_known(qu_in_t it, qu_out_t res);
    send_item(it);
    void'(expected_q.pop_back());
    expected_q.push_back(res);
  endtask

  always @(negedge clk) begin
    if (rst_n) out_ready <= stall_free ? 1'b1 : ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    qu_out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, out_data);
        err_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data !== exp_res) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, exp_res, out_data);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    qu_in_t dir_tab [$];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // known results: identity product, zero magnitude, normalised unit quaternion
    send_known(make_item(MODE_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0, 0),
               pack_res(16384, 0, 0, 0, 1'b1, 1'b0));
    send_known(make_item(MODE_NORM, 0, 0, 0, 0, -1, -1, -1, -1, -1),
               pack_res(0, 0, 0, 0, 1'b1, 1'b1));
    send_known(make_item(MODE_NORM, 16384, 0, 0, 0, 0, 0, 0, 0, 0),
               pack_res(16384, 0, 0, 0, 1'b1, 1'b0));

    dir_tab = {
      make_item(MODE_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0),
      make_item(MODE_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                -32768, 0),
      make_item(MODE_MUL, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                -32768, 32767),
      make_item(MODE_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0),
      make_item(MODE_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0),
      make_item(MODE_NORM, 0, 0, 0, -1, 0, 0, 0, 0, 0),
      make_item(MODE_NORM, 32767, -1, 1, 0, 0, 0, 0, 0, 0),
      make_item(MODE_MAT, 16384, 0, 0, 0, 0, 0, 0, 0, 0),
      make_item(MODE_MAT, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0),
      make_item(MODE_MAT, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0),
      make_item(MODE_MAT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      make_item(MODE_AXIS, 0, 16384, 0, 0, 0, 0, 0, 0, 0),
      make_item(MODE_AXIS, 0, 16384, 16384, 16384, 0, 0, 0, 0, 11520),
      make_item(MODE_AXIS, 0, 16384, 0, 0, 0, 0, 0, 0, 11521),
      make_item(MODE_AXIS, 0, 0, 16384, 0, 0, 0, 0, 0, -11520),
      make_item(MODE_AXIS, 0, 0, 0, 16384, 0, 0, 0, 0, -11521),
      make_item(MODE_AXIS, 0, 32767, -32768, 32767, 0, 0, 0, 0, 32767),
      make_item(MODE_AXIS, 0, -32768, 32767, -32768, 0, 0, 0, 0, -32768),
      make_item(MODE_AXIS, 0, 16384, 0, 0, 0, 0, 0, 0, 23040)
    };
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    in_valid <= 1'b0;

    // hold off until the directed results have all drained
    wait (expected_q.size() == 0);
    @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      busy_idle = !(n >= 150 && n < 230);
      stall_free = (n >= 150 && n < 230);
      send_item(random_item());
    end
    in_valid <= 1'b0;
    stall_free = 1'b1;

    wait (expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: quaternion_unit.f
sv/qu_pkg.sv
sv/qu_pipe.sv
sv/quaternion_unit.sv
sv/qu_checker.sv
sim/quaternion_unit_tb.sv
